// ===== hw/rtl/ipru_pkg.sv =====
// ----------------------------------------------------------------------------
// ipru_pkg: shared types and constants of the pixel replication upscaler
// Pixel layout, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ipru_pkg;

	// Widths of the configuration registers
	localparam int unsigned SCALE_REG_W   = 7;
	localparam int unsigned ROWPIX_REG_W  = 13;
	localparam int unsigned CFG_DATA_W    = 13;
	localparam int unsigned CFG_INDEX_W   = 1;

	// Pixel as stored in the line memory, blue in the lowest byte
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Input item kinds
	typedef enum logic {
		CMD_PIXEL  = 1'b0,
		CMD_REPLAY = 1'b1
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCALE_FACTOR     = 1'b0,
		REG_INPUT_ROW_PIXELS = 1'b1
	} cfg_reg_t;

endpackage

// ===== hw/rtl/ipru_line_mem.sv =====
// ----------------------------------------------------------------------------
// ipru_line_mem: line buffer of the pixel replication upscaler
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ipru_line_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  ipru_pkg::pixel_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ipru_pkg::pixel_t rd_data
);
	import ipru_pkg::*;

	pixel_t mem [DEPTH];
	pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/integer_pixel_replication_upscaler.sv =====
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler: nearest-neighbor integer upscaler
// Streams 24-bit pixels in raster order and replicates each one scale times
// horizontally; repeated rows are replayed from a line buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one beat per input item. s_tuser is the command
//   (pixel or replay), s_tdata carries the pixel bytes. A pixel beat is
//   written into the line buffer at the current column; a replay beat reads
//   the next buffered pixel. A replay beat with no repeated rows pending is
//   taken and dropped.
//   Master channel m_*: every productive input beat yields scale_factor
//   output beats; m_tlast marks the final copy of an input beat, m_tuser
//   marks the final pixel of an output row, and m_tdata also carries the
//   row padding count and the replay-pending flag.
//   Path: input beats go through the emit stage and the output register.
//   Throughput: one output beat per cycle unless m_* stalls; the emit stage
//   copy counter takes a new input beat with the final copy of the last one
//   (every cycle at factor 1). A replay read and a pixel write hit the line
//   buffer at the input beat, so no two accesses ever overlap on an entry.
//   Reset clears the column, the pending row count and both registers to 1;
//   the line buffer is not cleared. A stalled receiver holds the output
//   register, then the emit stage, then deasserts s_tready. The user writes
//   configuration via cfg_wen/cfg_index/cfg_wdata while idle; not enforced.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler #(
	parameter int unsigned MAX_ROW_PIXELS = 4096,
	parameter int unsigned MAX_SCALE      = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wen,
	input  logic [ipru_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ipru_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [23:0]                          s_tdata,  // blue_in, green_in, red_in
	input  logic                                 s_tuser,  // cmd
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [31:0]                          m_tdata,  // blue_out, green_out, red_out,
	                                                       // pad_bytes, replay_pending, zeros
	output logic                                 m_tuser,  // row_end
	output logic                                 m_tlast   // last
);
	import ipru_pkg::*;

	// Column address width, pending-row counter width, effective scale width
	localparam int unsigned CW   = $clog2(MAX_ROW_PIXELS);
	localparam int unsigned RW   = $clog2(MAX_SCALE);
	localparam int unsigned SW   = $clog2(MAX_SCALE + 1);
	localparam int unsigned CMPW = (CW + 1 > ROWPIX_REG_W) ? CW + 1 : ROWPIX_REG_W;

	// ---------------- configuration registers ----------------
	logic [SCALE_REG_W-1:0]  scale_q;
	logic [ROWPIX_REG_W-1:0] rowpix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_REG_W'(1);
			rowpix_q <= ROWPIX_REG_W'(1);
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCALE_FACTOR:     scale_q  <= cfg_wdata[SCALE_REG_W-1:0];
				REG_INPUT_ROW_PIXELS: rowpix_q <= cfg_wdata[ROWPIX_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective factor and row length: zero acts as one, clamp at the maximum
	logic [SW-1:0]   s_eff;
	logic [CMPW-1:0] w_eff;
	logic [3:0]      pad_prod;
	logic [1:0]      pad;

	always_comb begin
		if (scale_q == '0) begin
			s_eff = SW'(1);
		end else if (scale_q > SCALE_REG_W'(MAX_SCALE)) begin
			s_eff = SW'(MAX_SCALE);
		end else begin
			s_eff = scale_q[SW-1:0];
		end
		if (rowpix_q == '0) begin
			w_eff = CMPW'(1);
		end else if (CMPW'(rowpix_q) > CMPW'(MAX_ROW_PIXELS)) begin
			w_eff = CMPW'(MAX_ROW_PIXELS);
		end else begin
			w_eff = CMPW'(rowpix_q);
		end
	end

	// Row bytes are 3*w*s; the pad to a multiple of 4 reduces to (w*s) mod 4
	assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};
	assign pad      = pad_prod[1:0];

	// ---------------- control state ----------------
	logic [CW-1:0] column_q;
	logic [RW-1:0] rows_left_q;

	// ---------------- emit stage ----------------
	logic          busy_s1;
	logic          from_mem_s1;
	pixel_t        pix_s1;
	logic          row_end_s1;
	logic [1:0]    pad_s1;
	logic          pend_s1;
	logic [RW-1:0] cnt_s1;

	// ---------------- output register ----------------
	logic          out_valid_q;
	pixel_t        out_pix_q;
	logic [1:0]    out_pad_q;
	logic          out_pend_q;
	logic          out_row_end_q;
	logic          out_last_q;

	logic          out_free;
	logic          emit;
	logic          emit_fin;
	logic          in_acc;
	logic          is_pixel;
	logic          is_replay;
	logic          replay_live;
	logic [CW-1:0] col_cur;
	logic          row_end;
	logic [RW-1:0] rows_next;
	logic          pend_next;
	pixel_t        in_pix;
	pixel_t        mem_rd;
	pixel_t        emit_pix;

	assign out_free = !out_valid_q || m_tready;
	assign emit     = busy_s1 && out_free;
	assign emit_fin = emit && (cnt_s1 == '0);

	// Take a new beat when the emit stage is empty or sends its final copy
	assign s_tready  = !busy_s1 || emit_fin;
	assign in_acc    = s_tvalid && s_tready;
	assign is_pixel  = (cmd_t'(s_tuser) == CMD_PIXEL);
	assign is_replay = (cmd_t'(s_tuser) == CMD_REPLAY);
	assign replay_live = is_replay && (rows_left_q != '0);

	assign in_pix = pixel_t'(s_tdata);

	// A pixel while rows are pending cancels them and restarts at column 0
	always_comb begin
		if (is_pixel && (rows_left_q != '0)) begin
			col_cur = '0;
		end else begin
			col_cur = column_q;
		end
		row_end = ((CMPW'(col_cur) + CMPW'(1)) >= w_eff);
		if (is_pixel) begin
			rows_next = row_end ? RW'(s_eff - SW'(1)) : '0;
		end else if (row_end) begin
			rows_next = rows_left_q - RW'(1);
		end else begin
			rows_next = rows_left_q;
		end
		pend_next = (rows_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			rows_left_q <= '0;
		end else if (in_acc && (is_pixel || replay_live)) begin
			column_q    <= row_end ? '0 : col_cur + CW'(1);
			rows_left_q <= rows_next;
		end
	end

	// Line buffer: write on a pixel beat, read on a live replay beat
	ipru_line_mem #(
		.DEPTH (MAX_ROW_PIXELS),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (in_acc && is_pixel),
		.wr_addr (col_cur),
		.wr_data (in_pix),
		.rd_en   (in_acc && replay_live),
		.rd_addr (col_cur),
		.rd_data (mem_rd)
	);

	// Emit stage control: load on a productive beat, count copies down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			cnt_s1  <= '0;
		end else if (in_acc && (is_pixel || replay_live)) begin
			busy_s1 <= 1'b1;
			cnt_s1  <= RW'(s_eff - SW'(1));
		end else if (emit_fin) begin
			busy_s1 <= 1'b0;
		end else if (emit) begin
			cnt_s1 <= cnt_s1 - RW'(1);
		end
	end

	// Emit stage payload
	always_ff @(posedge clk) begin
		if (in_acc && (is_pixel || replay_live)) begin
			from_mem_s1 <= is_replay;
			pix_s1      <= in_pix;
			row_end_s1  <= row_end;
			pad_s1      <= pad;
			pend_s1     <= pend_next;
		end
	end

	// Read data stays put until the next replay read, which only comes after
	// this item has sent its final copy
	assign emit_pix = from_mem_s1 ? mem_rd : pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= busy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pix_q     <= emit_pix;
			out_last_q    <= (cnt_s1 == '0);
			out_row_end_q <= (cnt_s1 == '0) && row_end_s1;
			out_pad_q     <= ((cnt_s1 == '0) && row_end_s1) ? pad_s1 : 2'b00;
			out_pend_q    <= pend_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_pend_q, out_pad_q, out_pix_q};
	assign m_tuser  = out_row_end_q;
	assign m_tlast  = out_last_q;

	// ---------------- assertions ----------------
	// Column never leaves the line buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		column_q <= CW'(MAX_ROW_PIXELS - 1))
		else $error("column index beyond line buffer");

	// Row end only on the final copy of an item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("row end on a non-final copy");

	// A pixel beat that ends a row arms scale-1 repeated rows
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_pixel && row_end |=> rows_left_q == $past(RW'(s_eff - SW'(1))))
		else $error("pending rows not armed at row end");

	// A live replay beat loads the emit stage from the line buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && replay_live |=> busy_s1 && from_mem_s1)
		else $error("replay beat lost");

	// An idle replay beat changes no state
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_replay && !replay_live |=> $stable(column_q) && $stable(rows_left_q))
		else $error("idle replay changed state");

endmodule
